>>> hw/rtl/vfr_pkg.sv
// vfr_pkg: shared widths, constants and types of the vertex first-use renumber block
// no dependencies; compiled before every other file of the block

package vfr_pkg;

    localparam int IDX_W            = 16;
    localparam int CNT_W            = 17;
    localparam int EPOCH_W          = 8;
    localparam int TABLE_DEPTH_DEF  = 65536;
    localparam int VCOUNT_RESET     = 65536;

    localparam logic [EPOCH_W-1:0] EPOCH_CLEARED = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST   = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST    = '1;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   num;
    } t_entry;

    typedef struct packed {
        logic mesh_end;
    } t_epoch_req;

    typedef struct packed {
        logic               clearing;
        logic               last_epoch;
        logic [EPOCH_W-1:0] epoch;
    } t_epoch_st;

endpackage

>>> hw/rtl/vfr_if.sv
// vfr_if: valid/ready channel interfaces for the index stream and the result stream
// depends on vfr_pkg for field widths

interface vfr_in_if;
    import vfr_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;
    logic             end_of_mesh;

    modport source (output valid, output vertex_index, output end_of_mesh, input ready);
    modport sink   (input valid, input vertex_index, input end_of_mesh, output ready);
endinterface

interface vfr_out_if;
    import vfr_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] renum_index;
    logic             first_use;
    logic             out_of_range;
    logic [CNT_W-1:0] used_vertices;
    logic             mesh_done;

    modport source (
        output valid, output renum_index, output first_use, output out_of_range,
        output used_vertices, output mesh_done, input ready
    );
    modport sink (
        input valid, input renum_index, input first_use, input out_of_range,
        input used_vertices, input mesh_done, output ready
    );
endinterface

>>> hw/rtl/vfr_ram.sv
// vfr_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies; read during write to the same address returns the old data

module vfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vfr_epoch_ctrl.sv
// vfr_epoch_ctrl: mesh epoch counter and table clearing sweep
// depends on vfr_pkg; drives the clear address of the remap ram

module vfr_epoch_ctrl #(
    parameter int DEPTH = vfr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vfr_pkg::t_epoch_req      i_req,
    output vfr_pkg::t_epoch_st       o_st,
    output logic [$clog2(DEPTH)-1:0] o_clr_addr
);
    import vfr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic               r_clearing;
    logic               n_clearing;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      n_clr_addr;
    logic [EPOCH_W-1:0] r_epoch;
    logic [EPOCH_W-1:0] n_epoch;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end else if (i_req.mesh_end) begin
            if (r_epoch == EPOCH_LAST) begin
                n_epoch    = EPOCH_FIRST;
                n_clearing = 1'b1;
                n_clr_addr = '0;
            end else begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    assign o_st.clearing   = r_clearing;
    assign o_st.last_epoch = (r_epoch == EPOCH_LAST);
    assign o_st.epoch      = r_epoch;
    assign o_clr_addr      = r_clr_addr;

endmodule

>>> hw/rtl/vertex_first_use_renumber.sv
// vertex_first_use_renumber: renumbers vertex indices of a mesh in order of first use
// depends on vfr_pkg, vfr_if, vfr_ram and vfr_epoch_ctrl
//
// usage
//   i_in_ch carries one vertex_index per transfer, end_of_mesh on the last one of a mesh.
//   o_out_ch carries exactly one result per input transfer, in input order.
//   i_cfg_wr_en / i_cfg_wr_data write the vertex limit; write only while the block is idle.
// timing
//   one input transfer per cycle while ready is high (see stalls and clearing);
//   results pass the registered remap ram read and then the output register.
//   the remap ram is read once per item and written only on a first use; a write in the
//   cycle of the next read is forwarded.
// reset and clearing
//   each entry holds a number and the epoch of the mesh that wrote it; a mesh end bumps
//   the epoch. after reset, and after every 255th mesh end, a sweep clears every ram
//   entry, during which ready stays low; config writes still work.
// stalls
//   when o_out_ch is stalled the result waits in the output register, one more item
//   waits after the ram read, and ready drops until the output moves.

module vertex_first_use_renumber #(
    parameter int TABLE_DEPTH = vfr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    vfr_in_if.sink                  i_in_ch,
    vfr_out_if.source               o_out_ch,
    input  logic                    i_cfg_wr_en,
    input  logic [vfr_pkg::CNT_W-1:0] i_cfg_wr_data
);
    import vfr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = $bits(t_entry);
    localparam logic [CNT_W-1:0] MAXV = CNT_W'(TABLE_DEPTH);

    t_epoch_req    epoch_req;
    t_epoch_st     epoch_st;
    logic [AW-1:0] clr_addr;

    logic [CNT_W-1:0] r_vcount;

    logic          r_s1_valid;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_oor;
    logic          r_s1_eom;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_entry        r_fwd_data;

    logic [CNT_W-1:0] r_next;
    logic [CNT_W-1:0] n_next;

    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_new;
    logic             r_o_first;
    logic             r_o_oor;
    logic [CNT_W-1:0] r_o_used;
    logic             r_o_done;

    logic             in_ready;
    logic             in_xfer;
    logic             s1_adv;
    logic             s1_fire;
    logic             s1_wr;
    logic             hit;
    logic             in_oor;
    logic [CNT_W-1:0] idx_ext;
    logic [EW-1:0]    ram_rdata;
    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;

    vfr_epoch_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_epoch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (epoch_req),
        .o_st       (epoch_st),
        .o_clr_addr (clr_addr)
    );

    vfr_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_xfer),
        .i_raddr (i_in_ch.vertex_index[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // handshake and stage control
    assign s1_adv   = !r_o_valid || o_out_ch.ready;
    assign s1_fire  = r_s1_valid && s1_adv;
    assign in_ready = !epoch_st.clearing &&
                      (!r_s1_valid || (s1_adv && !(r_s1_eom && epoch_st.last_epoch)));
    assign in_xfer  = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    assign idx_ext = CNT_W'(i_in_ch.vertex_index);
    assign in_oor  = !((idx_ext < r_vcount) && (idx_ext < MAXV));

    // lookup with forwarding of the write made in the cycle of the read
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            rd_entry = r_fwd_data;
        end else begin
            rd_entry = t_entry'(ram_rdata);
        end
    end

    assign hit   = (rd_entry.epoch == epoch_st.epoch);
    assign s1_wr = s1_fire && !r_s1_oor && !hit;

    assign wr_entry.epoch = epoch_st.epoch;
    assign wr_entry.num   = r_next[IDX_W-1:0];

    always_comb begin
        if (epoch_st.clearing) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = EW'({EPOCH_CLEARED, {IDX_W{1'b0}}});
        end else begin
            ram_we    = s1_wr;
            ram_waddr = r_s1_addr;
            ram_wdata = wr_entry;
        end
    end

    assign epoch_req.mesh_end = s1_fire && r_s1_eom;

    always_comb begin
        n_next = r_next;
        if (s1_wr) begin
            n_next = r_next + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= CNT_W'(VCOUNT_RESET);
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_next      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_wr;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (epoch_req.mesh_end) begin
                r_next <= '0;
            end else begin
                r_next <= n_next;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_addr  <= i_in_ch.vertex_index[AW-1:0];
            r_s1_oor   <= in_oor;
            r_s1_eom   <= i_in_ch.end_of_mesh;
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= wr_entry;
        end
        if (s1_fire) begin
            r_o_oor   <= r_s1_oor;
            r_o_first <= s1_wr;
            r_o_used  <= n_next;
            r_o_done  <= r_s1_eom;
            if (r_s1_oor) begin
                r_o_new <= '0;
            end else if (hit) begin
                r_o_new <= rd_entry.num;
            end else begin
                r_o_new <= r_next[IDX_W-1:0];
            end
        end
    end

    assign o_out_ch.valid         = r_o_valid;
    assign o_out_ch.renum_index   = r_o_new;
    assign o_out_ch.first_use     = r_o_first;
    assign o_out_ch.out_of_range  = r_o_oor;
    assign o_out_ch.used_vertices = r_o_used;
    assign o_out_ch.mesh_done     = r_o_done;

    a_no_xfer_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        epoch_st.clearing |-> !in_xfer
    ) else $error("input transfer during table clear");

    a_count_cleared_after_mesh: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        epoch_req.mesh_end |=> (r_next == '0)
    ) else $error("vertex counter not cleared after mesh end");

    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_next <= MAXV
    ) else $error("vertex counter above table depth");

    a_first_use_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_first) |-> !r_o_oor
    ) else $error("first use reported for out-of-range index");

    a_no_pipe_write_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        epoch_st.clearing |-> !s1_fire
    ) else $error("lookup completed during table clear");

endmodule

>>> verif/vertex_first_use_renumber_test.sv
// vertex_first_use_renumber_test: self-checking bench for the first-use vertex renumber block
// drives index transfers with random gaps, predicts each result, compares results in order
// depends on vfr_pkg, vfr_if and vertex_first_use_renumber

module vertex_first_use_renumber_test;
    import vfr_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             end_of_mesh;
    } t_idx_item;

    typedef struct packed {
        logic [IDX_W-1:0] renum_index;
        logic             first_use;
        logic             out_of_range;
        logic [CNT_W-1:0] used_vertices;
        logic             mesh_done;
    } t_remap_result;

    localparam logic [CNT_W-1:0] VTX_LIMIT = CNT_W'(TABLE_DEPTH_DEF);
    localparam int WATCHDOG_LIMIT = 300000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;

    logic             in_valid = 1'b0;
    logic [IDX_W-1:0] in_index = '0;
    logic             in_eom   = 1'b0;
    logic             out_ready = 1'b0;

    vfr_in_if  in_ch ();
    vfr_out_if out_ch ();

    assign in_ch.valid        = in_valid;
    assign in_ch.vertex_index = in_index;
    assign in_ch.end_of_mesh  = in_eom;
    assign out_ch.ready       = out_ready;

    vertex_first_use_renumber u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .o_out_ch      (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    bit               seen_mark   [TABLE_DEPTH_DEF];
    logic [IDX_W-1:0] remap_model [TABLE_DEPTH_DEF];
    int unsigned      touched_q[$];
    logic [CNT_W-1:0] next_model   = '0;
    logic [CNT_W-1:0] vcount_model = CNT_W'(VCOUNT_RESET);

    t_idx_item     in_q[$];
    t_remap_result renumber_q[$];

    int  errors        = 0;
    int  items_queued  = 0;
    int  meshes_closed = 0;
    int  results_seen  = 0;
    int  send_gap      = 0;
    int  recv_gap      = 0;
    int  long_hold     = 0;
    int  quiet_cycles  = 0;
    bit  calm_tail     = 1'b0;

    function automatic t_remap_result renumber_vertex(t_idx_item it);
        t_remap_result    r;
        logic [CNT_W-1:0] lim;
        lim = (vcount_model > VTX_LIMIT) ? VTX_LIMIT : vcount_model;
        r = '0;
        if ({1'b0, it.vertex_index} < lim) begin
            if (seen_mark[it.vertex_index]) begin
                r.renum_index = remap_model[it.vertex_index];
            end else begin
                r.renum_index = next_model[IDX_W-1:0];
                remap_model[it.vertex_index] = next_model[IDX_W-1:0];
                seen_mark[it.vertex_index] = 1'b1;
                touched_q.insert(touched_q.size(), it.vertex_index);
                next_model = next_model + 1'b1;
                r.first_use = 1'b1;
            end
        end else begin
            r.out_of_range = 1'b1;
        end
        r.used_vertices = next_model;
        r.mesh_done = it.end_of_mesh;
        if (it.end_of_mesh) begin
            foreach (touched_q[k]) seen_mark[touched_q[k]] = 1'b0;
            touched_q.delete();
            next_model = '0;
        end
        return r;
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(t_remap_result got);
        t_remap_result want;
        if (renumber_q.size() == 0) begin
            $display("%0t: result with nothing pending, expected none actual renum_index %0h",
                     $time, got.renum_index);
            errors++;
            return;
        end
        want = renumber_q.pop_front();
        compare_field("renum_index", want.renum_index, got.renum_index);
        compare_field("first_use", want.first_use, got.first_use);
        compare_field("out_of_range", want.out_of_range, got.out_of_range);
        compare_field("used_vertices", want.used_vertices, got.used_vertices);
        compare_field("mesh_done", want.mesh_done, got.mesh_done);
    endtask

    // driver: one transfer held until accepted, random gaps after transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ch.ready) begin
                renumber_q.insert(renumber_q.size(), renumber_vertex(in_q.pop_front()));
                if (!calm_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
            end
            if (!(in_valid && !in_ch.ready)) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap--;
                end else if (in_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_index <= in_q[0].vertex_index;
                    in_eom   <= in_q[0].end_of_mesh;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer, random stalls and two long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ready && out_ch.valid) begin
                check_result({out_ch.renum_index, out_ch.first_use, out_ch.out_of_range,
                              out_ch.used_vertices, out_ch.mesh_done});
                results_seen++;
                if (results_seen == 30 || results_seen == 700) long_hold = 120;
            end
            if (long_hold != 0) begin
                out_ready <= 1'b0;
                long_hold--;
            end else if (recv_gap != 0) begin
                out_ready <= 1'b0;
                recv_gap--;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 18);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ch.ready) || (out_ready && out_ch.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_item(logic [IDX_W-1:0] idx, logic eom);
        in_q.insert(in_q.size(), '{vertex_index: idx, end_of_mesh: eom});
        items_queued++;
        if (eom) meshes_closed++;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] lim, int unsigned base);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return IDX_W'($urandom_range(0, 65535));
        if (roll == 1) return IDX_W'(lim - 1'b1);
        if (roll == 2) return IDX_W'(lim);
        return IDX_W'(base + $urandom_range(0, 7));
    endfunction

    task automatic queue_mesh(logic [CNT_W-1:0] lim, int len, bit close);
        int unsigned base;
        base = (lim > 8) ? $urandom_range(0, lim - 8) : 0;
        for (int k = 0; k < len; k++) push_item(pick_index(lim, base), close && k == len - 1);
    endtask

    task automatic write_vcount(logic [CNT_W-1:0] v);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        vcount_model = v;
        @(negedge i_clk);
    endtask

    task automatic drain;
        while (in_q.size() != 0 || renumber_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [CNT_W-1:0] v;
        logic [CNT_W-1:0] lim;
        int               n_meshes;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit, both extremes and alternating bit patterns
        push_item(16'd0, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd0, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'h5555, 1'b0);
        push_item(16'hAAAA, 1'b0);
        push_item(16'h5555, 1'b1);
        drain();

        // out of range items, one of them closing the mesh
        write_vcount(17'd16);
        push_item(16'd3, 1'b0);
        push_item(16'd15, 1'b0);
        push_item(16'd16, 1'b0);
        push_item(16'd3, 1'b0);
        push_item(16'hFFFF, 1'b1);
        drain();

        // limit lowered in mid-mesh
        push_item(16'd5, 1'b0);
        push_item(16'd9, 1'b0);
        push_item(16'd10, 1'b0);
        drain();
        write_vcount(17'd8);
        push_item(16'd9, 1'b0);
        push_item(16'd5, 1'b0);
        push_item(16'd7, 1'b1);
        drain();

        write_vcount('0);
        push_item(16'd0, 1'b0);
        push_item(16'd1, 1'b1);
        drain();

        // above the saturation point
        write_vcount('1);
        push_item(16'hFFFF, 1'b0);
        push_item(16'd0, 1'b0);
        push_item(16'hFFFF, 1'b1);
        drain();

        write_vcount(17'd1);
        push_item(16'd0, 1'b0);
        push_item(16'd1, 1'b0);
        push_item(16'd0, 1'b1);
        drain();

        // enough meshes to pass the epoch wrap at least once
        while (items_queued < 1150 || meshes_closed < 270) begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = 17'd1;
                2:       v = VTX_LIMIT;
                3:       v = CNT_W'($urandom_range(65537, 131071));
                4:       v = '1;
                5, 6:    v = CNT_W'($urandom_range(1, 65536));
                default: v = CNT_W'($urandom_range(2, 64));
            endcase
            write_vcount(v);
            lim = (v > VTX_LIMIT) ? VTX_LIMIT : v;
            n_meshes = $urandom_range(2, 12);
            repeat (n_meshes) begin
                queue_mesh(lim, ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24)
                                                             : $urandom_range(1, 5), 1'b1);
            end
            if ($urandom_range(0, 3) == 0) queue_mesh(lim, $urandom_range(1, 4), 1'b0);
            drain();
            @(negedge i_clk);
            if (items_queued >= 1000 && meshes_closed >= 260) calm_tail = 1'b1;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
